FILE: design/sha_pkg.sv
// SHA-256 package: state enum, round constants, initial hash values, round helpers.
// Used by sha256_message_digest.
`timescale 1ns / 1ps
package sha_pkg;
    localparam int LEN_BITS = 61;

    typedef enum logic [3:0] {
        ST_IDLE, ST_LOAD, ST_ROUND, ST_UPDATE, ST_PADDING, ST_LENGTH, ST_EMIT
    } t_state;

    function automatic logic [31:0] iv_word(input logic [2:0] i);
        logic [31:0] r;
        case (i)
            3'd0: r = 32'h6a09e667;
            3'd1: r = 32'hbb67ae85;
            3'd2: r = 32'h3c6ef372;
            3'd3: r = 32'ha54ff53a;
            3'd4: r = 32'h510e527f;
            3'd5: r = 32'h9b05688c;
            3'd6: r = 32'h1f83d9ab;
            default: r = 32'h5be0cd19;
        endcase
        return r;
    endfunction

    localparam logic [31:0] K_TAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] ror(input logic [31:0] v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction
endpackage

FILE: design/sha_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module sha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_addr] <= i_wdata;
        o_rdata <= r_mem[i_addr];
    end
endmodule

FILE: design/sha256_message_digest.sv
// SHA-256 digest engine: byte stream in, eight digest words out.
// A byte that does not fill a block is written to the byte-wide block RAM; a full
// block is read back from the RAM into the message schedule window and then runs
// the rounds and the update, and no byte is taken until that is done. Closing adds
// padding writes, one or two compressions and 8 output transfers. Synchronous
// active-low reset loads the initial hash values and clears fill and length counts;
// the block RAM is not cleared.
// Depends on sha_pkg and sha_ram.
`timescale 1ns / 1ps
module sha256_message_digest (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
    input  logic        s_axis_tlast,  // end_of_message
    input  logic        s_axis_tuser,  // byte_valid
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // [31:0] digest_word, [34:32] word_index, rest 0
    output logic        m_axis_tlast   // last_word
);
    import sha_pkg::*;

    t_state r_state, n_state;
    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic [31:0] r_w [16];        // message schedule window
    logic [5:0]  r_fill;
    logic [LEN_BITS-1:0] r_len;
    logic [6:0]  r_cnt;           // load/round/pad counter
    logic        r_last;          // closing in progress
    logic        r_pad_done;      // final block (with length) under way
    logic        r_rd_ok;         // RAM read data valid in load
    logic [2:0]  r_oidx;

    // RAM port
    logic       ram_we;
    logic [5:0] ram_addr;
    logic [7:0] ram_wdata, ram_rdata;

    sha_ram #(.WIDTH(8), .DEPTH(64)) u_buf (
        .i_clk(i_clk), .i_we(ram_we), .i_addr(ram_addr),
        .i_wdata(ram_wdata), .o_rdata(ram_rdata)
    );

    wire acc = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    wire [6:0] fill_inc = {1'b0, r_fill} + 7'd1;
    wire [63:0] bits = 64'(r_len) << 3;

    // byte of the 64-bit length at block position 56+k
    logic [7:0] len_byte;
    always_comb begin
        len_byte = 8'h00;
        case (r_cnt[2:0])
            3'd0: len_byte = bits[63:56];
            3'd1: len_byte = bits[55:48];
            3'd2: len_byte = bits[47:40];
            3'd3: len_byte = bits[39:32];
            3'd4: len_byte = bits[31:24];
            3'd5: len_byte = bits[23:16];
            3'd6: len_byte = bits[15:8];
            default: len_byte = bits[7:0];
        endcase
    end

    // round logic
    logic [31:0] w_next, t1, t2, s0, s1;
    always_comb begin
        s0 = ror(r_w[1], 7) ^ ror(r_w[1], 18) ^ (r_w[1] >> 3);
        s1 = ror(r_w[14], 17) ^ ror(r_w[14], 19) ^ (r_w[14] >> 10);
        w_next = r_w[0] + s0 + r_w[9] + s1;
        t1 = r_v[7] + (ror(r_v[4], 6) ^ ror(r_v[4], 11) ^ ror(r_v[4], 25))
           + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + K_TAB[r_cnt[5:0]] + r_w[0];
        t2 = (ror(r_v[0], 2) ^ ror(r_v[0], 13) ^ ror(r_v[0], 22))
           + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (acc) begin
                if (s_axis_tuser && fill_inc[6:0] == 7'd64) n_state = ST_LOAD;
                else if (s_axis_tlast) n_state = ST_PADDING;
            end
            ST_LOAD:   if (r_cnt == 7'd64) n_state = ST_ROUND;
            ST_ROUND:  if (r_cnt == 7'd63) n_state = ST_UPDATE;
            ST_UPDATE: begin
                if (!r_last) n_state = ST_IDLE;
                else if (r_pad_done) n_state = ST_EMIT;
                else n_state = ST_PADDING;
            end
            ST_PADDING: if (r_cnt == 7'd63) n_state = (r_fill >= 6'd56) ? ST_LOAD : ST_LENGTH;
            ST_LENGTH: if (r_cnt[2:0] == 3'd7) n_state = ST_LOAD;
            ST_EMIT:   if (m_axis_tready && r_oidx == 3'd7) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // RAM access
    always_comb begin
        ram_we = 1'b0;
        ram_addr = r_cnt[5:0];
        ram_wdata = 8'h00;
        unique case (r_state)
            ST_IDLE: begin
                ram_we = acc && s_axis_tuser;
                ram_addr = r_fill;
                ram_wdata = s_axis_tdata;
            end
            ST_PADDING: begin
                ram_we = (r_cnt[5:0] >= r_fill) && !(r_fill >= 6'd56 && r_pad_done);
                // second pass (block with only zeros) clears 0..63
                ram_wdata = (r_cnt[5:0] == r_fill && !r_pad_done) ? 8'h80 : 8'h00;
            end
            ST_LENGTH: begin
                ram_we = 1'b1;
                ram_addr = {3'b111, r_cnt[2:0]};
                ram_wdata = len_byte;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill <= '0;
            r_len <= '0;
            r_cnt <= '0;
            r_last <= 1'b0;
            r_pad_done <= 1'b0;
            r_rd_ok <= 1'b0;
            r_oidx <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= iv_word(3'(i));
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ST_IDLE: begin
                    r_cnt <= '0;
                    r_rd_ok <= 1'b0;
                    if (acc) begin
                        r_last <= s_axis_tlast;
                        if (s_axis_tuser) begin
                            r_fill <= fill_inc[5:0];
                            r_len <= r_len + 1'b1;
                        end
                        // padding begins at the new fill
                    end
                end
                ST_LOAD: begin
                    // address r_cnt is read; data arrives next cycle
                    if (r_rd_ok) begin
                        // first byte of a word: advance the window one word
                        if (r_cnt[1:0] == 2'd1) begin
                            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                            r_w[15] <= {24'h000000, ram_rdata};
                        end else begin
                            r_w[15] <= {r_w[15][23:0], ram_rdata};
                        end
                    end
                    if (r_cnt == 7'd64) begin
                        r_cnt <= '0;
                        for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                    end else begin
                        r_cnt <= r_cnt + 7'd1;
                    end
                    r_rd_ok <= 1'b1;
                end
                ST_ROUND: begin
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                    r_w[15] <= w_next;
                    r_v[0] <= t1 + t2; r_v[1] <= r_v[0]; r_v[2] <= r_v[1];
                    r_v[3] <= r_v[2];  r_v[4] <= r_v[3] + t1; r_v[5] <= r_v[4];
                    r_v[6] <= r_v[5];  r_v[7] <= r_v[6];
                    r_cnt <= r_cnt + 7'd1;
                end
                ST_UPDATE: begin
                    for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                    r_cnt <= '0;
                    r_rd_ok <= 1'b0;
                    if (!r_last) r_fill <= '0;
                    else if (!r_pad_done && r_fill >= 6'd56) begin
                        // first pad block done; next pass writes zeros 0..63
                        r_pad_done <= 1'b1;
                        r_fill <= '0;
                    end
                end
                ST_PADDING: begin
                    if (r_cnt == 7'd63) begin
                        r_cnt <= '0;
                        if (r_fill < 6'd56) r_pad_done <= 1'b1;
                    end else begin
                        r_cnt <= r_cnt + 7'd1;
                    end
                    r_rd_ok <= 1'b0;
                end
                ST_LENGTH: begin
                    r_cnt <= (r_cnt[2:0] == 3'd7) ? 7'd0 : r_cnt + 7'd1;
                    r_rd_ok <= 1'b0;
                end
                ST_EMIT: begin
                    if (m_axis_tready) begin
                        r_oidx <= r_oidx + 3'd1;
                        if (r_oidx == 3'd7) begin
                            for (int i = 0; i < 8; i++) r_h[i] <= iv_word(3'(i));
                            r_fill <= '0;
                            r_len <= '0;
                            r_last <= 1'b0;
                            r_pad_done <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // outputs
    always_comb begin
        m_axis_tvalid = (r_state == ST_EMIT);
        m_axis_tdata = {5'd0, r_oidx, r_h[r_oidx]};
        m_axis_tlast = (r_oidx == 3'd7);
    end

    property p_emit_idx_reset;
        @(posedge i_clk) disable iff (!i_rst_n)
        ($rose(m_axis_tvalid)) |-> (r_oidx == 3'd0);
    endproperty
    a_emit_idx: assert property (p_emit_idx_reset) else $error("emit index not zero");

    a_no_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !s_axis_tready) else $error("ready while busy");

    a_last_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> (r_state == ST_IDLE && r_len == '0))
        else $error("state not reinitialized after digest");
endmodule
